[rtl/mpbo_pkg.sv]
// Package: payload structs, MD5 round constants and index helpers for the obfuscation block.
package mpbo_pkg;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic [31:0] session_id;
		logic [7:0]  version_byte;
		logic [7:0]  sequence_number;
	} mpbo_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} mpbo_out_t;

	localparam logic [31:0] MD5_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [31:0] MD5_IV [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	// Message word index used by a round.
	function automatic logic [3:0] md5_g(input logic [5:0] rnd);
		logic [3:0] i;
		logic [3:0] g;
		i = rnd[3:0];
		case (rnd[5:4])
			2'd0:    g = i;
			2'd1:    g = 4'((i << 2) + i + 4'd1);
			2'd2:    g = 4'((i << 1) + i + 4'd5);
			default: g = 4'((i << 3) - i);
		endcase
		return g;
	endfunction

	// Rotate amount used by a round.
	function automatic logic [4:0] md5_s(input logic [5:0] rnd);
		logic [4:0] s;
		case ({rnd[5:4], rnd[1:0]})
			4'd0:    s = 5'd7;
			4'd1:    s = 5'd12;
			4'd2:    s = 5'd17;
			4'd3:    s = 5'd22;
			4'd4:    s = 5'd5;
			4'd5:    s = 5'd9;
			4'd6:    s = 5'd14;
			4'd7:    s = 5'd20;
			4'd8:    s = 5'd4;
			4'd9:    s = 5'd11;
			4'd10:   s = 5'd16;
			4'd11:   s = 5'd23;
			4'd12:   s = 5'd6;
			4'd13:   s = 5'd10;
			4'd14:   s = 5'd15;
			default: s = 5'd21;
		endcase
		return s;
	endfunction

endpackage

[rtl/mpbo_round.sv]
// Shared MD5 round unit: one step of the compression function per use.
module mpbo_round (
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	input  logic [31:0] d,
	input  logic [31:0] km,
	input  logic [5:0]  rnd,
	output logic [31:0] b_next
);
	import mpbo_pkg::*;

	logic [31:0] f;
	logic [31:0] t;
	logic [63:0] rot_w;
	logic [4:0]  s;

	// Select the round function by quarter
	always_comb begin
		case (rnd[5:4])
			2'd0:    f = (b & c) | (~b & d);
			2'd1:    f = (d & b) | (~d & c);
			2'd2:    f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
	end

	// Add, rotate, add
	assign t      = f + a + km;
	assign s      = md5_s(rnd);
	assign rot_w  = {t, t} << s;
	assign b_next = b + rot_w[63:32];

endmodule

[rtl/md5_pad_body_obfuscator_unit.sv]
// Top level: MD5 pad stream obfuscation of packet body bytes, one byte per item.
//
// Usage:
//   Input items (in_data) carry one body byte plus first/last marks and the
//   header fields; the header is latched when first_byte is set, which also
//   restarts the pad chain. Each item gives one output item (out_data): the
//   byte XOR the current pad byte, and the last mark copied.
//   The key is loaded through cfg_we/cfg_index/cfg_wdata while idle:
//   index 0 is key_length, indexes 1..6 are key words 0..5.
// Processing:
//   A byte that needs no new pad goes through accept and emit.
//   A byte at pad position 0 (or with first_byte set) runs the shared MD5
//   round unit one round per cycle: accept, init, 64 rounds and finish per
//   block, then emit. The message spans two blocks when a long key is
//   combined with the chained pad.
//   in_stall is high while a byte is being worked on.
// Reset: arst_n clears key, held header, pad position and chain state.
// Output stall: the output register holds its item; one more input item may
//   be accepted and waits in its emit step until the register is free.
module md5_pad_body_obfuscator_unit #(
	parameter int MAX_KEY_BYTES = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mpbo_pkg::mpbo_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mpbo_pkg::mpbo_out_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_wdata
);
	import mpbo_pkg::*;

	localparam int KEY_WORDS = (MAX_KEY_BYTES + 7) / 8;
	localparam int KEY_BYTES = KEY_WORDS * 8;
	localparam int KB_W      = $clog2(KEY_BYTES);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INIT  = 3'd1;
	localparam logic [2:0] S_ROUND = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0]  st_q;
	logic [5:0]  key_length_q;
	logic [63:0] key_q [KEY_WORDS];
	logic [7:0]  key_b [KEY_BYTES];
	logic [31:0] held_session_q;
	logic [7:0]  held_version_q;
	logic [7:0]  held_sequence_q;
	logic [7:0]  pad_q [16];
	logic [3:0]  pos_q;
	logic        chained_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic [31:0] h_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] km_q;
	logic [5:0]  rnd_q;
	logic        blk_q;
	logic        out_valid_q;
	mpbo_out_t   out_q;

	logic [5:0]  klen;
	logic [6:0]  msg_len;
	logic        two_blocks;
	logic [6:0]  lbase;
	logic        fblk;
	logic [5:0]  frnd;
	logic [3:0]  fg;
	logic [7:0]  mb [4];
	logic [31:0] mword;
	logic [31:0] km_next;
	logic [31:0] b_next;
	logic [31:0] hn [4];
	logic        accept;
	logic        emit_go;

	assign accept  = in_valid && (st_q == S_IDLE);
	assign emit_go = (st_q == S_EMIT) && (!out_valid_q || !out_stall);

	// Message layout from the key length and chain state
	assign klen       = (key_length_q > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : key_length_q;
	assign msg_len    = 7'd6 + {1'b0, klen} + (chained_q ? 7'd16 : 7'd0);
	assign two_blocks = (msg_len >= 7'd56);
	assign lbase      = two_blocks ? 7'd120 : 7'd56;

	// Flatten key bytes
	always_comb begin
		for (int k = 0; k < KEY_BYTES; k++) begin
			key_b[k] = key_q[k / 8][(k % 8) * 8 +: 8];
		end
	end

	// Pick which block and round the next message word is fetched for
	always_comb begin
		unique case (st_q)
			S_INIT:  begin fblk = 1'b0;  frnd = 6'd0; end
			S_FIN:   begin fblk = 1'b1;  frnd = 6'd0; end
			default: begin fblk = blk_q; frnd = 6'(rnd_q + 6'd1); end
		endcase
	end
	assign fg = md5_g(frnd);

	// Build the four message bytes of the fetched word
	always_comb begin
		logic [6:0] p;
		logic [6:0] kidx;
		logic [6:0] pidx;
		logic [6:0] kend;
		for (int j = 0; j < 4; j++) begin
			p    = {fblk, fg, 2'(j)};
			kidx = p - 7'd4;
			kend = 7'd4 + {1'b0, klen};
			pidx = p - kend - 7'd2;
			if (p < 7'd4) begin
				mb[j] = held_session_q[8 * (3 - j) +: 8];
			end else if (p < kend) begin
				mb[j] = key_b[kidx[KB_W-1:0]];
			end else if (p == kend) begin
				mb[j] = held_version_q;
			end else if (p == kend + 7'd1) begin
				mb[j] = held_sequence_q;
			end else if (chained_q && (p < kend + 7'd18)) begin
				mb[j] = pad_q[pidx[3:0]];
			end else if (p == msg_len) begin
				mb[j] = 8'h80;
			end else if (p == lbase) begin
				mb[j] = {msg_len[4:0], 3'b000};
			end else if (p == lbase + 7'd1) begin
				mb[j] = {6'b0, msg_len[6:5]};
			end else begin
				mb[j] = 8'h00;
			end
		end
	end
	assign mword   = {mb[3], mb[2], mb[1], mb[0]};
	assign km_next = MD5_K[frnd] + mword;

	mpbo_round u_round (
		.a      (a_q),
		.b      (b_q),
		.c      (c_q),
		.d      (d_q),
		.km     (km_q),
		.rnd    (rnd_q),
		.b_next (b_next)
	);

	// Chaining values after a block
	assign hn[0] = h_q[0] + a_q;
	assign hn[1] = h_q[1] + b_q;
	assign hn[2] = h_q[2] + c_q;
	assign hn[3] = h_q[3] + d_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= 6'd0;
			for (int k = 0; k < KEY_WORDS; k++) key_q[k] <= 64'd0;
		end else if (cfg_we) begin
			if (cfg_index == 3'd0) key_length_q <= cfg_wdata[5:0];
			for (int k = 0; k < KEY_WORDS; k++) begin
				if (cfg_index == 3'(k + 1)) key_q[k] <= cfg_wdata;
			end
		end
	end

	// Sequence accept, hash rounds and emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q            <= S_IDLE;
			pos_q           <= 4'd0;
			chained_q       <= 1'b0;
			held_session_q  <= 32'd0;
			held_version_q  <= 8'd0;
			held_sequence_q <= 8'd0;
			rnd_q           <= 6'd0;
			blk_q           <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						if (in_data.first_byte) begin
							held_session_q  <= in_data.session_id;
							held_version_q  <= in_data.version_byte;
							held_sequence_q <= in_data.sequence_number;
							chained_q       <= 1'b0;
							pos_q           <= 4'd0;
						end
						st_q <= (in_data.first_byte || pos_q == 4'd0) ? S_INIT : S_EMIT;
					end
				end
				S_INIT: begin
					rnd_q <= 6'd0;
					blk_q <= 1'b0;
					st_q  <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= 6'(rnd_q + 6'd1);
					if (rnd_q == 6'd63) st_q <= S_FIN;
				end
				S_FIN: begin
					if (!blk_q && two_blocks) begin
						blk_q <= 1'b1;
						rnd_q <= 6'd0;
						st_q  <= S_ROUND;
					end else begin
						chained_q <= 1'b1;
						st_q      <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						pos_q <= 4'(pos_q + 4'd1);
						st_q  <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Hold the working variables, pad and item byte
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= in_data.data_byte;
			last_q <= in_data.last_byte;
		end
		case (st_q)
			S_INIT: begin
				for (int w = 0; w < 4; w++) h_q[w] <= MD5_IV[w];
				a_q  <= MD5_IV[0];
				b_q  <= MD5_IV[1];
				c_q  <= MD5_IV[2];
				d_q  <= MD5_IV[3];
				km_q <= km_next;
			end
			S_ROUND: begin
				a_q  <= d_q;
				b_q  <= b_next;
				c_q  <= b_q;
				d_q  <= c_q;
				km_q <= km_next;
			end
			S_FIN: begin
				for (int w = 0; w < 4; w++) h_q[w] <= hn[w];
				a_q  <= hn[0];
				b_q  <= hn[1];
				c_q  <= hn[2];
				d_q  <= hn[3];
				km_q <= km_next;
				if (blk_q || !two_blocks) begin
					for (int i = 0; i < 16; i++) pad_q[i] <= hn[i / 4][(i % 4) * 8 +: 8];
				end
			end
			default: ;
		endcase
	end

	// Drive the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_q.out_byte <= data_q ^ pad_q[pos_q];
			out_q.out_last <= last_q;
		end
	end

	assign in_stall  = (st_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_ROUND && rnd_q == 6'd63) |=> st_q == S_FIN)
		else $error("round counter did not end block");
	a_emit_load: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (out_valid_q && st_q == S_IDLE))
		else $error("emit did not load output register");
	a_second_blk: assert property (@(posedge clk) disable iff (!arst_n)
		(blk_q && (st_q == S_ROUND || st_q == S_FIN)) |-> two_blocks)
		else $error("second block without long message");
	a_pad_ready: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_EMIT |-> chained_q)
		else $error("emit without pad");

endmodule
